// ===== design/ghalloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ghalloc_pkg;

	// Sizes fixed by the field definitions
	localparam int MIN_FREE_WIDTH = 11;
	localparam int EVENT_WIDTH    = 4;
	localparam int OP_WIDTH       = 2;
	localparam int STATUS_WIDTH   = 2;

	// Defaults for the top-level parameters
	localparam int INDEX_WIDTH_DEFAULT      = 10;
	localparam int GENERATION_WIDTH_DEFAULT = 8;

	localparam logic [MIN_FREE_WIDTH-1:0] MIN_FREE_RESET = MIN_FREE_WIDTH'(32);

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// Request opcodes
	localparam logic [OP_WIDTH-1:0] OP_ALLOCATE  = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_DESTROY   = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_SUBSCRIBE = 2'd2;

	// Result status codes
	localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_UNISSUED = 2'd2;

	// Decoded command class
	typedef enum logic [1:0] {
		K_ALLOC,
		K_DESTROY,
		K_SUBSCRIBE,
		K_NOP
	} kind_t;

endpackage
`default_nettype wire

// ===== design/ghalloc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ghalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/ghalloc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ghalloc_front #(
	parameter int INDEX_WIDTH = ghalloc_pkg::INDEX_WIDTH_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [ghalloc_pkg::OP_WIDTH-1:0]    operation,
	input  wire logic [INDEX_WIDTH-1:0]              index,
	input  wire logic [ghalloc_pkg::EVENT_WIDTH-1:0] event_mask,
	output logic                                     cmd_valid,
	input  wire logic                                cmd_ready,
	output ghalloc_pkg::kind_t                       cmd_kind,
	output logic      [INDEX_WIDTH-1:0]              cmd_index,
	output logic      [ghalloc_pkg::EVENT_WIDTH-1:0] cmd_mask
);
	import ghalloc_pkg::*;

	localparam int QAW = $clog2(CMDQ_DEPTH);

	kind_t                  kind;
	kind_t                  kind_q  [CMDQ_DEPTH];
	logic [INDEX_WIDTH-1:0] index_q [CMDQ_DEPTH];
	logic [EVENT_WIDTH-1:0] mask_q  [CMDQ_DEPTH];
	logic [QAW-1:0]         wr_ptr_q;
	logic [QAW-1:0]         rd_ptr_q;
	logic [QAW:0]           count_q;
	logic                   push;
	logic                   pop;

	// classify the opcode; unused code becomes a no-op
	always_comb begin
		case (operation)
			OP_ALLOCATE:  kind = K_ALLOC;
			OP_DESTROY:   kind = K_DESTROY;
			OP_SUBSCRIBE: kind = K_SUBSCRIBE;
			default:      kind = K_NOP;
		endcase
	end

	assign in_ready  = count_q != (QAW+1)'(CMDQ_DEPTH);
	assign cmd_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_kind  = kind_q[rd_ptr_q];
	assign cmd_index = index_q[rd_ptr_q];
	assign cmd_mask  = mask_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]  <= kind;
			index_q[wr_ptr_q] <= index;
			mask_q[wr_ptr_q]  <= event_mask;
		end
	end

endmodule
`default_nettype wire

// ===== design/ghalloc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ghalloc_back #(
	parameter int INDEX_WIDTH      = ghalloc_pkg::INDEX_WIDTH_DEFAULT,
	parameter int GENERATION_WIDTH = ghalloc_pkg::GENERATION_WIDTH_DEFAULT
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ghalloc_pkg::MIN_FREE_WIDTH-1:0] cfg_wdata,
	input  wire logic                                   cmd_valid,
	output logic                                        cmd_ready,
	input  wire ghalloc_pkg::kind_t                     cmd_kind,
	input  wire logic [INDEX_WIDTH-1:0]                 cmd_index,
	input  wire logic [ghalloc_pkg::EVENT_WIDTH-1:0]    cmd_mask,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic      [ghalloc_pkg::STATUS_WIDTH-1:0]   status,
	output logic      [INDEX_WIDTH-1:0]                 handle_index,
	output logic      [GENERATION_WIDTH-1:0]            generation
);
	import ghalloc_pkg::*;

	localparam int IW        = INDEX_WIDTH;
	localparam int GW        = GENERATION_WIDTH;
	localparam int SW        = GW + EVENT_WIDTH;
	localparam int SLOTS     = 1 << IW;
	localparam int CW        = (IW + 1 > MIN_FREE_WIDTH) ? IW + 1 : MIN_FREE_WIDTH;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_POP  = 3'd1;  // free-list read in flight
	localparam logic [2:0] B_GEN  = 3'd2;  // slot read for reused index
	localparam logic [2:0] B_RMW  = 3'd3;  // slot read-modify-write
	localparam logic [2:0] B_RES  = 3'd4;  // hand result to output reg

	logic [2:0]          state_q;
	logic [IW-1:0]       free_head_q;
	logic [IW-1:0]       free_tail_q;
	logic [IW:0]         free_count_q;
	logic [IW:0]         next_fresh_q;
	logic [MIN_FREE_WIDTH-1:0] min_free_q;
	logic                out_valid_q;

	kind_t               cur_kind_q;
	logic [IW-1:0]       cur_index_q;
	logic [EVENT_WIDTH-1:0] cur_mask_q;
	logic [STATUS_WIDTH-1:0] res_status_q;
	logic [IW-1:0]       res_index_q;
	logic [GW-1:0]       res_gen_q;
	logic [STATUS_WIDTH-1:0] out_status_q;
	logic [IW-1:0]       out_index_q;
	logic [GW-1:0]       out_gen_q;

	logic                take;
	logic                is_alloc;
	logic                is_slot_op;
	logic                reuse_ok;
	logic                fresh_ok;
	logic                pop_sel;
	logic                fresh_sel;
	logic                issued;
	logic                cur_destroy;
	logic                count_full;
	logic                can_out;

	logic                fifo_we;
	logic                fifo_re;
	logic [IW-1:0]       fifo_rdata;
	logic                slot_we;
	logic [IW-1:0]       slot_waddr;
	logic [SW-1:0]       slot_wdata;
	logic                slot_re;
	logic [IW-1:0]       slot_raddr;
	logic [SW-1:0]       slot_rdata;
	logic [GW-1:0]       gen_rd;
	logic [GW-1:0]       gen_new;
	logic [EVENT_WIDTH-1:0] flags_new;

	assign take       = (state_q == B_IDLE) && cmd_valid;
	assign cmd_ready  = state_q == B_IDLE;
	assign is_alloc   = cmd_kind == K_ALLOC;
	assign is_slot_op = (cmd_kind == K_DESTROY) || (cmd_kind == K_SUBSCRIBE);

	// source choice for allocate
	assign reuse_ok  = CW'(free_count_q) > CW'(min_free_q);
	assign fresh_ok  = !next_fresh_q[IW];
	assign pop_sel   = reuse_ok || (!fresh_ok && (free_count_q != '0));
	assign fresh_sel = !pop_sel && fresh_ok;
	assign issued    = {1'b0, cmd_index} < next_fresh_q;

	assign cur_destroy = cur_kind_q == K_DESTROY;
	assign count_full  = free_count_q[IW];
	assign can_out     = !out_valid_q || out_ready;

	assign gen_rd    = slot_rdata[SW-1:EVENT_WIDTH];
	assign gen_new   = cur_destroy ? gen_rd + GW'(1) : gen_rd;
	assign flags_new = cur_destroy ? '0 : cur_mask_q;

	// free-list memory
	assign fifo_re = take && is_alloc && pop_sel;
	assign fifo_we = (state_q == B_RMW) && cur_destroy && !count_full;

	ghalloc_ram #(
		.WIDTH (IW),
		.DEPTH (SLOTS)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (free_tail_q),
		.wdata (cur_index_q),
		.re    (fifo_re),
		.raddr (free_head_q),
		.rdata (fifo_rdata)
	);

	// slot memory: {generation, event flags}; entries past next_fresh are never read
	assign slot_re    = (state_q == B_POP) || (take && is_slot_op && issued);
	assign slot_raddr = (state_q == B_POP) ? fifo_rdata : cmd_index;
	assign slot_we    = (take && is_alloc && fresh_sel) || (state_q == B_RMW);
	assign slot_waddr = (state_q == B_RMW) ? cur_index_q : next_fresh_q[IW-1:0];
	assign slot_wdata = (state_q == B_RMW) ? {gen_new, flags_new} : '0;

	ghalloc_ram #(
		.WIDTH (SW),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_count_q <= '0;
			next_fresh_q <= '0;
			min_free_q   <= MIN_FREE_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_free_q <= cfg_wdata;
			end
			if ((state_q == B_RES) && can_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (take) begin
						if (is_alloc && pop_sel) begin
							free_head_q  <= free_head_q + 1'b1;
							free_count_q <= free_count_q - 1'b1;
							state_q      <= B_POP;
						end else if (is_slot_op && issued) begin
							state_q <= B_RMW;
						end else begin
							if (is_alloc && fresh_sel) begin
								next_fresh_q <= next_fresh_q + 1'b1;
							end
							state_q <= B_RES;
						end
					end
				end
				B_POP: state_q <= B_GEN;
				B_GEN: state_q <= B_RES;
				B_RMW: begin
					if (cur_destroy && !count_full) begin
						free_tail_q  <= free_tail_q + 1'b1;
						free_count_q <= free_count_q + 1'b1;
					end
					state_q <= B_RES;
				end
				B_RES: begin
					if (can_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (take) begin
					cur_kind_q  <= cmd_kind;
					cur_index_q <= cmd_index;
					cur_mask_q  <= cmd_mask;
					if (is_alloc) begin
						if (fresh_sel) begin
							res_status_q <= ST_OK;
							res_index_q  <= next_fresh_q[IW-1:0];
							res_gen_q    <= '0;
						end else begin
							res_status_q <= ST_EMPTY;
							res_index_q  <= '0;
							res_gen_q    <= '0;
						end
					end else if (is_slot_op) begin
						res_status_q <= ST_UNISSUED;
						res_index_q  <= cmd_index;
						res_gen_q    <= '0;
					end else begin
						res_status_q <= ST_OK;
						res_index_q  <= cmd_index;
						res_gen_q    <= '0;
					end
				end
			end
			B_POP: cur_index_q <= fifo_rdata;
			B_GEN: begin
				res_status_q <= ST_OK;
				res_index_q  <= cur_index_q;
				res_gen_q    <= gen_rd;
			end
			B_RMW: begin
				res_status_q <= ST_OK;
				res_index_q  <= cur_index_q;
				res_gen_q    <= gen_new;
			end
			B_RES: begin
				if (can_out) begin
					out_status_q <= res_status_q;
					out_index_q  <= res_index_q;
					out_gen_q    <= res_gen_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign handle_index = out_index_q;
	assign generation   = out_gen_q;

endmodule
`default_nettype wire

// ===== design/generational_handle_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generational handle allocator.
// Request channel in_valid/in_ready carries operation, index, event_mask;
// one beat in gives exactly one result beat on out_valid/out_ready
// (status, handle_index, generation), in request order.
// The user must write min_free through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
// Front end: opcode decode into a two-entry command queue, so requests
// keep landing while the back end works or the result waits.
// Back end: one request at a time against two single-port-per-side RAMs
// with registered reads (free list, and generation plus event flags).
// States per request in the back end: a fresh allocate, a no-op or a
// request that fails goes from B_IDLE straight to B_RES; destroy and
// subscribe pass through B_RMW (slot read-modify-write); a reusing
// allocate passes B_POP then B_GEN (free-list read, then slot read).
// Reset clears counters and queue; min_free returns to 32. No RAM clearing
// pass: slots are written on fresh issue before they can ever be read.
// A stalled receiver holds the result in the output register; the back end
// parks one more result, the queue fills, and in_ready drops after at most
// three more beats.
module generational_handle_allocator #(
	parameter int INDEX_WIDTH      = ghalloc_pkg::INDEX_WIDTH_DEFAULT,
	parameter int GENERATION_WIDTH = ghalloc_pkg::GENERATION_WIDTH_DEFAULT
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ghalloc_pkg::MIN_FREE_WIDTH-1:0] cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [ghalloc_pkg::OP_WIDTH-1:0]       operation,
	input  wire logic [INDEX_WIDTH-1:0]                 index,
	input  wire logic [ghalloc_pkg::EVENT_WIDTH-1:0]    event_mask,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic      [ghalloc_pkg::STATUS_WIDTH-1:0]   status,
	output logic      [INDEX_WIDTH-1:0]                 handle_index,
	output logic      [GENERATION_WIDTH-1:0]            generation
);
	import ghalloc_pkg::*;

	// decoded command from the queue head
	logic                   cmd_valid;
	logic                   cmd_ready;
	kind_t                  cmd_kind;
	logic [INDEX_WIDTH-1:0] cmd_index;
	logic [EVENT_WIDTH-1:0] cmd_mask;

	ghalloc_front #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.index      (index),
		.event_mask (event_mask),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_kind   (cmd_kind),
		.cmd_index  (cmd_index),
		.cmd_mask   (cmd_mask)
	);

	// sequencer, counters, RAMs and output register
	ghalloc_back #(
		.INDEX_WIDTH      (INDEX_WIDTH),
		.GENERATION_WIDTH (GENERATION_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_kind     (cmd_kind),
		.cmd_index    (cmd_index),
		.cmd_mask     (cmd_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.handle_index (handle_index),
		.generation   (generation)
	);

endmodule
`default_nettype wire

// ===== design/ghalloc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ghalloc_checker #(
	parameter int INDEX_WIDTH      = ghalloc_pkg::INDEX_WIDTH_DEFAULT,
	parameter int GENERATION_WIDTH = ghalloc_pkg::GENERATION_WIDTH_DEFAULT
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [ghalloc_pkg::STATUS_WIDTH-1:0] status,
	input wire logic [INDEX_WIDTH-1:0]               handle_index,
	input wire logic [GENERATION_WIDTH-1:0]          generation
);
	import ghalloc_pkg::*;

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(handle_index) && $stable(generation))
		else $error("result beat changed while stalled");

	// exhausted allocate reports index and generation zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (handle_index == '0) && (generation == '0))
		else $error("empty result carries nonzero fields");

	// request on an index never issued reports generation zero
	a_unissued: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNISSUED) |-> (generation == '0))
		else $error("unissued result carries a generation");

	// no result beat while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

endmodule

bind generational_handle_allocator ghalloc_checker #(
	.INDEX_WIDTH      (INDEX_WIDTH),
	.GENERATION_WIDTH (GENERATION_WIDTH)
) u_ghalloc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.handle_index (handle_index),
	.generation   (generation)
);
`default_nettype wire

// ===== dv/tb_generational_handle_allocator.sv =====
`timescale 1ns / 1ps
module tb_generational_handle_allocator;
	import ghalloc_pkg::*;

	localparam int IDX_W          = INDEX_WIDTH_DEFAULT;
	localparam int GEN_W          = GENERATION_WIDTH_DEFAULT;
	localparam int SLOTS          = 1 << IDX_W;
	localparam int WATCHDOG_LIMIT = 2000;
	// Opcode the block treats as a no-op
	localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0] status;
		logic [IDX_W-1:0]        handle_index;
		logic [GEN_W-1:0]        generation;
	} alloc_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [MIN_FREE_WIDTH-1:0]  cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic [OP_WIDTH-1:0]        operation;
	logic [IDX_W-1:0]           index;
	logic [EVENT_WIDTH-1:0]     event_mask;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_WIDTH-1:0]    status;
	logic [IDX_W-1:0]           handle_index;
	logic [GEN_W-1:0]           generation;

	generational_handle_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.index        (index),
		.event_mask   (event_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.handle_index (handle_index),
		.generation   (generation)
	);

	// Shadow allocator state, advanced once per accepted request beat
	logic [GEN_W-1:0]          gen_mem [SLOTS];
	logic [EVENT_WIDTH-1:0]    flag_mem [SLOTS];
	logic [IDX_W-1:0]          free_ring [$];
	int                        fresh_next;
	logic [MIN_FREE_WIDTH-1:0] mf_cfg;

	alloc_result_t expected_results [$];
	int            fail_count   = 0;
	int            quiet_cycles = 0;
	int            snd_idle_pct = 0;
	int            rcv_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Returns what the block should answer and applies the request's side effects.
	function automatic alloc_result_t predict_request(input logic [OP_WIDTH-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [EVENT_WIDTH-1:0] mask);
		alloc_result_t r;
		logic [IDX_W-1:0] got;
		r.status       = ST_OK;
		r.handle_index = idx;
		r.generation   = '0;
		case (op)
			OP_ALLOCATE: begin
				// Reuse only once more than min_free are waiting; fall back to
				// the ring when fresh slots are gone.
				if (free_ring.size() > int'(mf_cfg)) begin
					got = free_ring.pop_front();
				end else if (fresh_next < SLOTS) begin
					got = IDX_W'(fresh_next);
					fresh_next++;
					gen_mem[got] = '0;
				end else if (free_ring.size() > 0) begin
					got = free_ring.pop_front();
				end else begin
					r.status       = ST_EMPTY;
					r.handle_index = '0;
					return r;
				end
				r.handle_index = got;
				r.generation   = gen_mem[got];
			end
			OP_DESTROY, OP_SUBSCRIBE: begin
				if (int'(idx) >= fresh_next) begin
					r.status = ST_UNISSUED;
				end else if (op == OP_DESTROY) begin
					gen_mem[idx] = gen_mem[idx] + 1'b1;
					// full ring: generation still bumps, slot just isn't queued
					if (free_ring.size() < SLOTS)
						free_ring.insert(free_ring.size(), idx);
					flag_mem[idx] = '0;
					r.generation  = gen_mem[idx];
				end else begin
					flag_mem[idx] = mask;
					r.generation  = gen_mem[idx];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] pick_issued();
		return IDX_W'($urandom_range(0, fresh_next - 1));
	endfunction

	task automatic set_idling(input int snd_pct, input int rcv_pct);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
	endtask

	// One request beat. Valid stays up after acceptance so back-to-back beats
	// never lower and raise it in the same step; it drops only on an idle cycle.
	task automatic send_request(input logic [OP_WIDTH-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [EVENT_WIDTH-1:0] mask);
		alloc_result_t want;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		index      <= idx;
		event_mask <= mask;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = predict_request(op, idx, mask);
		expected_results.insert(expected_results.size(), want);
	endtask

	// Holds off the sender until every outstanding result has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Only called with the block drained.
	task automatic write_min_free(input logic [MIN_FREE_WIDTH-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mf_cfg = value;
	endtask

	task automatic send_random_request();
		int               roll;
		logic [IDX_W-1:0] idx;
		logic [OP_WIDTH-1:0] op;
		roll = $urandom_range(0, 99);
		if (roll < 40)      op = OP_ALLOCATE;
		else if (roll < 70) op = OP_DESTROY;
		else if (roll < 90) op = OP_SUBSCRIBE;
		else                op = OP_UNUSED;
		// mostly target live slots so destroy/subscribe get past the issue check
		if (fresh_next > 0 && $urandom_range(0, 99) < 85 &&
				(op == OP_DESTROY || op == OP_SUBSCRIBE))
			idx = pick_issued();
		else
			idx = IDX_W'($urandom_range(0, SLOTS - 1));
		send_request(op, idx, EVENT_WIDTH'($urandom_range(0, 15)));
	endtask

	// Edge cases at the reset value of min_free, then the reuse threshold.
	task automatic test_directed();
		set_idling(35, 66);
		// nothing issued yet: index 0 and the top index are both rejected
		send_request(OP_SUBSCRIBE, '0, 4'hF);
		send_request(OP_DESTROY, '1, 4'h0);
		send_request(OP_UNUSED, '1, 4'hF);
		send_request(OP_UNUSED, '0, 4'h0);
		send_request(OP_ALLOCATE, '1, 4'hF);
		send_request(OP_ALLOCATE, '0, 4'h0);
		// first index past the issued range
		send_request(OP_DESTROY, IDX_W'(2), 4'h0);
		send_request(OP_SUBSCRIBE, IDX_W'(1), 4'hF);
		send_request(OP_SUBSCRIBE, IDX_W'(1), 4'h0);
		// same slot destroyed twice sits in the ring twice
		send_request(OP_DESTROY, '0, 4'h5);
		send_request(OP_DESTROY, '0, 4'hA);
		send_request(OP_SUBSCRIBE, '0, 4'hA);
		send_request(OP_ALLOCATE, '0, 4'h0);
		// sender pause: everything back before the register moves
		wait_drain();
		write_min_free('0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		send_request(OP_DESTROY, IDX_W'(3), 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		// min_free 1: one waiting slot is not enough, two are
		wait_drain();
		write_min_free(MIN_FREE_WIDTH'(1));
		send_request(OP_DESTROY, IDX_W'(1), 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		send_request(OP_DESTROY, IDX_W'(2), 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
	endtask

	task automatic test_random_mix(input int count, input logic [MIN_FREE_WIDTH-1:0] mf);
		wait_drain();
		write_min_free(mf);
		repeat (count) send_random_request();
	endtask

	// Use up every fresh slot; meanwhile a hot slot takes enough destroys to
	// wrap its generation. min_free 1024 keeps the ring from being reused here.
	task automatic test_pool_exhaust();
		logic [IDX_W-1:0] hot;
		int               roll;
		int               hot_left;
		wait_drain();
		write_min_free(MIN_FREE_WIDTH'(1024));
		hot      = pick_issued();
		hot_left = 260;
		while (fresh_next < SLOTS || hot_left > 0) begin
			roll = $urandom_range(0, 99);
			if (fresh_next < SLOTS && (roll < 75 || hot_left == 0)) begin
				send_request(OP_ALLOCATE, IDX_W'($urandom), EVENT_WIDTH'($urandom));
			end else if (hot_left > 0 && roll < 97) begin
				send_request(OP_DESTROY, hot, EVENT_WIDTH'($urandom));
				hot_left--;
			end else begin
				send_request(OP_SUBSCRIBE, pick_issued(), EVENT_WIDTH'($urandom));
			end
		end
	endtask

	// Pop the ring dry with fresh slots gone, then hit the empty case.
	task automatic test_pool_drain();
		wait_drain();
		write_min_free(MIN_FREE_WIDTH'(1023));
		while (free_ring.size() > 0) begin
			if ($urandom_range(0, 9) == 0)
				send_request(OP_SUBSCRIBE, pick_issued(), EVENT_WIDTH'($urandom));
			else
				send_request(OP_ALLOCATE, IDX_W'($urandom), EVENT_WIDTH'($urandom));
		end
		repeat (3) send_request(OP_ALLOCATE, IDX_W'($urandom), EVENT_WIDTH'($urandom));
		send_request(OP_DESTROY, pick_issued(), 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
		send_request(OP_ALLOCATE, '0, 4'h0);
	endtask

	// Receiver side: ready toggles per the current idle rate.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

	// Result checker: every result beat against the oldest expectation.
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d index %0d gen %0d",
					status, handle_index, generation);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (handle_index !== want.handle_index) begin
					$error("handle_index: expected %0d, got %0d", want.handle_index, handle_index);
					fail_count++;
				end
				if (generation !== want.generation) begin
					$error("generation: expected %0d, got %0d", want.generation, generation);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: no beat on either side for too long ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		operation  <= '0;
		index      <= '0;
		event_mask <= '0;
		out_ready  <= 1'b0;
		foreach (gen_mem[i]) begin
			gen_mem[i]  = '0;
			flag_mem[i] = '0;
		end
		fresh_next = 0;
		mf_cfg     = MIN_FREE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(100, '0);
		set_idling(66, 35);
		test_random_mix(100, MIN_FREE_WIDTH'($urandom_range(2, 40)));
		test_pool_exhaust();
		set_idling(0, 0);
		test_pool_drain();
		// post-exhaustion: allocations only ever come from the ring or fail
		test_random_mix(100, '0);

		wait_drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
